// ===== hw/rtl/bplc_pkg.sv =====
// ----------------------------------------------------------------------------
// bplc_pkg
// shared types and constants of the button press level classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bplc_pkg;

  localparam int unsigned NUM_THR    = 5;
  localparam int unsigned THR_W      = 32;
  localparam int unsigned LVL_W      = 3;
  localparam int unsigned CFG_AW     = 5;
  localparam int unsigned CFG_DW     = 32;

  localparam logic [THR_W-1:0] THR_RESET [NUM_THR] = '{
    32'd300, 32'd1000, 32'd2000, 32'd0, 32'd0
  };
  localparam logic [LVL_W-1:0] LEVELS_IN_USE_RESET = 3'd3;
  localparam logic             POLARITY_RESET      = 1'b0;
  localparam logic [LVL_W-1:0] TOGGLE_MIN_RESET    = 3'd2;

  typedef enum logic [2:0] {
    REG_THR_A      = 3'd0,
    REG_THR_B      = 3'd1,
    REG_THR_C      = 3'd2,
    REG_THR_D      = 3'd3,
    REG_THR_E      = 3'd4,
    REG_LEVELS     = 3'd5,
    REG_POLARITY   = 3'd6,
    REG_TOGGLE_MIN = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_THR-1:0][THR_W-1:0] thr;
    logic [LVL_W-1:0]              levels_in_use;
    logic                          pressed_polarity;
    logic [LVL_W-1:0]              toggle_min_level;
  } cfg_t;

  typedef struct packed {
    logic             release_event;
    logic [LVL_W-1:0] press_level;
    logic             is_pressed;
    logic             relay_on;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bplc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bplc_cfg_regs
// apb register file holding thresholds, level count, polarity and toggle level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bplc_cfg_regs
  import bplc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THR; i++) begin
        cfg_q.thr[i] <= THR_RESET[i];
      end
      cfg_q.levels_in_use    <= LEVELS_IN_USE_RESET;
      cfg_q.pressed_polarity <= POLARITY_RESET;
      cfg_q.toggle_min_level <= TOGGLE_MIN_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_THR_A:      cfg_q.thr[0]           <= pwdata;
        REG_THR_B:      cfg_q.thr[1]           <= pwdata;
        REG_THR_C:      cfg_q.thr[2]           <= pwdata;
        REG_THR_D:      cfg_q.thr[3]           <= pwdata;
        REG_THR_E:      cfg_q.thr[4]           <= pwdata;
        REG_LEVELS:     cfg_q.levels_in_use    <= pwdata[LVL_W-1:0];
        REG_POLARITY:   cfg_q.pressed_polarity <= pwdata[0];
        REG_TOGGLE_MIN: cfg_q.toggle_min_level <= pwdata[LVL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_THR_A:      prdata = cfg_q.thr[0];
      REG_THR_B:      prdata = cfg_q.thr[1];
      REG_THR_C:      prdata = cfg_q.thr[2];
      REG_THR_D:      prdata = cfg_q.thr[3];
      REG_THR_E:      prdata = cfg_q.thr[4];
      REG_LEVELS:     prdata = CFG_DW'(cfg_q.levels_in_use);
      REG_POLARITY:   prdata = CFG_DW'(cfg_q.pressed_polarity);
      REG_TOGGLE_MIN: prdata = CFG_DW'(cfg_q.toggle_min_level);
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bplc_step.sv =====
// ----------------------------------------------------------------------------
// bplc_step
// press tracking state and combinational level classification of one sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bplc_step
  import bplc_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             raw_level_i,
  input  wire logic [THR_W-1:0] now_ms_i,
  input  wire cfg_t             cfg_i,
  output res_t                  res_o
);

  localparam int unsigned LevelCap = (MAX_LEVELS < NUM_THR) ? MAX_LEVELS : NUM_THR;

  logic             pressed_q, pressed_d;
  logic [THR_W-1:0] start_q, start_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             relay_q, relay_d;
  logic             release_d;
  logic [THR_W-1:0] held;
  logic [LVL_W-1:0] active_n;
  logic [LVL_W-1:0] met_level;

  // active level count clamped to the cap
  always_comb begin
    active_n = cfg_i.levels_in_use;
    if (active_n > LVL_W'(LevelCap)) begin
      active_n = LVL_W'(LevelCap);
    end
  end

  assign held = now_ms_i - start_q;

  // last threshold in use that the held time meets, keep level otherwise
  always_comb begin
    met_level = level_q;
    for (int i = 0; i < NUM_THR; i++) begin
      if ((LVL_W'(i) < active_n) && (held >= cfg_i.thr[i])) begin
        met_level = LVL_W'(i + 1);
      end
    end
  end

  always_comb begin
    pressed_d = pressed_q;
    start_d   = start_q;
    level_d   = level_q;
    relay_d   = relay_q;
    release_d = 1'b0;
    if (raw_level_i == cfg_i.pressed_polarity) begin
      if (!pressed_q) begin
        pressed_d = 1'b1;
        start_d   = now_ms_i;
        level_d   = '0;
      end else begin
        level_d = met_level;
      end
    end else if (pressed_q) begin
      pressed_d = 1'b0;
      release_d = 1'b1;
      if (level_q >= cfg_i.toggle_min_level) begin
        relay_d = !relay_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      start_q   <= '0;
      level_q   <= '0;
      relay_q   <= 1'b0;
    end else if (en_i) begin
      pressed_q <= pressed_d;
      start_q   <= start_d;
      level_q   <= level_d;
      relay_q   <= relay_d;
    end
  end

  assign res_o.release_event = release_d;
  assign res_o.press_level   = level_d;
  assign res_o.is_pressed    = pressed_d;
  assign res_o.relay_on      = relay_d;

endmodule

`default_nettype wire

// ===== hw/rtl/button_press_level_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_press_level_classifier_core
// classifies button presses by hold time and toggles a relay on release
// ----------------------------------------------------------------------------
// an accepted request is held in the input register and its result moves to the
// result register when the output is free; throughput: 1 request per cycle while
// the output is not stalled, set by the step logic between the two registers
// reset: async active low, press state idle, relay off, config registers at defaults
`timescale 1ns / 1ps
`default_nettype none

module button_press_level_classifier_core
  import bplc_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              raw_level_i,
  input  wire logic [THR_W-1:0]  now_ms_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   release_event_o,
  output logic      [LVL_W-1:0]  press_level_o,
  output logic                   is_pressed_o,
  output logic                   relay_on_o
);

  cfg_t             cfg;
  res_t             res;
  res_t             res_q;
  logic             in_valid_q, in_valid_d;
  logic             in_raw_q;
  logic [THR_W-1:0] in_now_q;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             advance;
  logic             in_take;

  bplc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bplc_step #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .raw_level_i (in_raw_q),
    .now_ms_i    (in_now_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = out_free ? advance : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_raw_q <= raw_level_i;
      in_now_q <= now_ms_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign release_event_o = res_q.release_event;
  assign press_level_o   = res_q.press_level;
  assign is_pressed_o    = res_q.is_pressed;
  assign relay_on_o      = res_q.relay_on;

  a_release_ends_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && release_event_o |-> !is_pressed_o)
    else $error("release reported while press still in progress");

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (press_level_o <= LVL_W'(NUM_THR)))
    else $error("press level beyond threshold count");

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled without a held request");

  a_result_after_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced request produced no result");

endmodule

`default_nettype wire
